### rtl/core/slal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slal_pkg
// Shared types, constants and helpers of the symbol list address lookup.
// ----------------------------------------------------------------------------
package slal_pkg;

    localparam int ADDR_BITS_DEF = 32;
    localparam int NAME_LEN_DEF  = 64;
    localparam int LOOKUP_W      = 32;
    localparam int SYM_ADDR_W    = 32;
    localparam int CHAR_W        = 8;

    localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHR_QMARK   = 8'h3F;
    localparam logic [CHAR_W-1:0] CHR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHR_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_PRINT_HI = 8'h7E;
    localparam logic [CHAR_W-1:0] CHR_DIG_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_DIG_9   = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_LC_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LC_F    = 8'h66;
    localparam logic [CHAR_W-1:0] CHR_UC_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UC_F    = 8'h46;
    localparam logic [CHAR_W-1:0] HEX_ALPHA_OFS = 8'd10;

    typedef enum logic [1:0] {
        STAT_FOUND    = 2'd0,
        STAT_ENDED    = 2'd1,
        STAT_BAD_NAME = 2'd2,
        STAT_FORMAT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        NM_STORED,
        NM_EMPTY,
        NM_QMARK
    } t_name_mode;

    typedef struct packed {
        logic [CHAR_W-1:0] list_byte;
        logic              scan_start;
    } t_item;

    typedef struct packed {
        logic [1:0]            status;
        logic [SYM_ADDR_W-1:0] symbol_address;
        logic [CHAR_W-1:0]     name_char;
        logic                  last;
    } t_result;

    typedef logic [LOOKUP_W-1:0] t_cfg_word;

    // byte classification and emission progress, datapath to controller
    typedef struct packed {
        logic is_hex;
        logic is_space;
        logic is_newline;
        logic is_print;
        logic acc_above;
        logic name_full;
        logic emit_last;
    } t_dp_status;

    // controller to datapath
    typedef struct packed {
        logic       restart;
        logic       acc_first;
        logic       acc_shift;
        logic       prev_take;
        logic       len_clear;
        logic       name_write;
        logic       report;
        t_status    rep_status;
        t_name_mode rep_mode;
        logic       emit_load;
        logic       emit_next;
    } t_dp_cmd;

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        logic [4:0]        res;
        v   = '0;
        res = '0;
        if (c >= CHR_DIG_0 && c <= CHR_DIG_9) begin
            v   = c - CHR_DIG_0;
            res = {1'b1, v[3:0]};
        end else if (c >= CHR_LC_A && c <= CHR_LC_F) begin
            v   = c - CHR_LC_A + HEX_ALPHA_OFS;
            res = {1'b1, v[3:0]};
        end else if (c >= CHR_UC_A && c <= CHR_UC_F) begin
            v   = c - CHR_UC_A + HEX_ALPHA_OFS;
            res = {1'b1, v[3:0]};
        end
        return res;
    endfunction

endpackage

### rtl/core/slal_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slal_chan_if
// Valid/ready channel carrying one word of a chosen payload type.
// ----------------------------------------------------------------------------
interface slal_chan_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/slal_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slal_datapath
// Hex accumulator, lookup register, name store and report registers.
// ----------------------------------------------------------------------------
module slal_datapath import slal_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int NAME_LEN  = NAME_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_cfg_word         i_cfg_data,
    input  logic [CHAR_W-1:0] i_byte,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    output t_result           o_result
);

    localparam int IDX_W = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
    localparam int LEN_W = $clog2(NAME_LEN + 1);
    localparam int CMP_W = (ADDR_BITS > LOOKUP_W) ? ADDR_BITS : LOOKUP_W;

    logic [LOOKUP_W-1:0]  r_lookup;
    logic [ADDR_BITS-1:0] r_acc;
    logic [ADDR_BITS-1:0] r_prev;
    logic [LEN_W-1:0]     r_len;
    logic [CHAR_W-1:0]    r_store [NAME_LEN];
    logic [CHAR_W-1:0]    r_rd_data;
    logic                 r_last;
    t_status              r_rep_status;
    t_name_mode           r_rep_mode;
    logic [SYM_ADDR_W-1:0] r_rep_addr;
    logic [LEN_W-1:0]     r_rep_len;
    logic [IDX_W-1:0]     r_k;

    logic [4:0]           hex;
    logic [ADDR_BITS-1:0] eff_prev;
    logic [LEN_W-1:0]     eff_len;
    logic [ADDR_BITS-1:0] rep_src;
    logic [CMP_W-1:0]     rep_wide;
    logic [CMP_W-1:0]     acc_wide;
    logic [CMP_W-1:0]     lookup_wide;

    assign hex         = hex_decode(i_byte);
    assign acc_wide    = CMP_W'(r_acc);
    assign lookup_wide = CMP_W'(r_lookup);

    // a restart in the same cycle reports from the cleared scan state
    assign eff_prev = i_cmd.restart ? '0 : r_prev;
    assign eff_len  = i_cmd.restart ? '0 : r_len;
    assign rep_src  = (i_cmd.rep_status == STAT_BAD_NAME) ? r_acc : eff_prev;
    assign rep_wide = CMP_W'(rep_src);

    always_comb begin
        o_status.is_hex     = hex[4];
        o_status.is_space   = (i_byte == CHR_SPACE);
        o_status.is_newline = (i_byte == CHR_NEWLINE);
        o_status.is_print   = (i_byte >= CHR_PRINT_LO) && (i_byte <= CHR_PRINT_HI);
        o_status.acc_above  = (acc_wide > lookup_wide);
        o_status.name_full  = (r_len == LEN_W'(NAME_LEN));
        o_status.emit_last  = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookup <= '0;
            r_acc    <= '0;
            r_prev   <= '0;
            r_len    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_lookup <= i_cfg_data;
            end
            if (i_cmd.restart) begin
                r_acc  <= '0;
                r_prev <= '0;
                r_len  <= '0;
            end
            if (i_cmd.acc_first) begin
                r_acc <= ADDR_BITS'(hex[3:0]);
            end else if (i_cmd.acc_shift) begin
                r_acc <= {r_acc[ADDR_BITS-5:0], hex[3:0]};
            end
            if (i_cmd.prev_take) begin
                r_prev <= r_acc;
            end
            if (i_cmd.len_clear) begin
                r_len <= '0;
            end else if (i_cmd.name_write) begin
                r_len <= r_len + LEN_W'(1);
            end
        end
    end

    // report latch and emission counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_rep_status <= i_cmd.rep_status;
            r_rep_addr   <= rep_wide[SYM_ADDR_W-1:0];
            r_rep_len    <= eff_len;
            r_k          <= '0;
            if (i_cmd.rep_mode == NM_STORED && eff_len == '0) begin
                r_rep_mode <= NM_EMPTY;
            end else begin
                r_rep_mode <= i_cmd.rep_mode;
            end
        end else if (i_cmd.emit_next) begin
            r_k <= r_k + IDX_W'(1);
        end
        if (i_cmd.emit_load) begin
            r_last <= (r_rep_mode != NM_STORED) ||
                      (LEN_W'(r_k) + LEN_W'(1) == r_rep_len);
        end
    end

    // name store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.name_write) begin
            r_store[r_len[IDX_W-1:0]] <= i_byte;
        end
        if (i_cmd.emit_load) begin
            r_rd_data <= r_store[r_k];
        end
    end

    always_comb begin
        o_result.status         = r_rep_status;
        o_result.symbol_address = r_rep_addr;
        o_result.last           = r_last;
        unique case (r_rep_mode)
            NM_STORED: o_result.name_char = r_rd_data;
            NM_QMARK:  o_result.name_char = CHR_QMARK;
            default:   o_result.name_char = CHR_NUL;
        endcase
    end

endmodule

### rtl/core/slal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slal_ctrl
// Line parser and report sequencer state machine.
// ----------------------------------------------------------------------------
module slal_ctrl import slal_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_scan_start,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_LINE,
        ST_HEX,
        ST_NAME,
        ST_LOAD,
        ST_SHOW,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state eff_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    assign accept    = i_in_valid && r_in_ready;
    assign eff_state = (accept && i_scan_start) ? ST_LINE : r_state;

    always_comb begin
        o_cmd         = '0;
        o_cmd.rep_status = STAT_FOUND;
        o_cmd.rep_mode   = NM_STORED;
        o_cmd.restart = accept && i_scan_start;
        n_state       = r_state;
        unique case (eff_state)
            ST_LINE: begin
                if (accept) begin
                    if (i_status.is_hex) begin
                        o_cmd.acc_first = 1'b1;
                        n_state         = ST_HEX;
                    end else begin
                        o_cmd.report     = 1'b1;
                        o_cmd.rep_status = STAT_ENDED;
                        n_state          = ST_LOAD;
                    end
                end
            end
            ST_HEX: begin
                if (accept) begin
                    if (i_status.is_hex) begin
                        o_cmd.acc_shift = 1'b1;
                    end else if (i_status.acc_above) begin
                        o_cmd.report     = 1'b1;
                        o_cmd.rep_status = STAT_FOUND;
                        n_state          = ST_LOAD;
                    end else if (!i_status.is_space) begin
                        o_cmd.report     = 1'b1;
                        o_cmd.rep_status = STAT_FORMAT;
                        o_cmd.rep_mode   = NM_EMPTY;
                        n_state          = ST_LOAD;
                    end else begin
                        o_cmd.len_clear = 1'b1;
                        n_state         = ST_NAME;
                    end
                end
            end
            ST_NAME: begin
                if (accept) begin
                    if (i_status.is_newline) begin
                        o_cmd.prev_take = 1'b1;
                        n_state         = ST_LINE;
                    end else if (i_status.name_full) begin
                        o_cmd.report     = 1'b1;
                        o_cmd.rep_status = STAT_FORMAT;
                        o_cmd.rep_mode   = NM_EMPTY;
                        n_state          = ST_LOAD;
                    end else if (!i_status.is_print) begin
                        o_cmd.report     = 1'b1;
                        o_cmd.rep_status = STAT_BAD_NAME;
                        o_cmd.rep_mode   = NM_QMARK;
                        n_state          = ST_LOAD;
                    end else begin
                        o_cmd.name_write = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.emit_load = 1'b1;
                n_state         = ST_SHOW;
            end
            ST_SHOW: begin
                if (i_out_ready) begin
                    if (i_status.emit_last) begin
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state         = ST_LOAD;
                    end
                end
            end
            ST_DONE: begin
                // words are swallowed until a scan start
                n_state = ST_DONE;
            end
            default: begin
                n_state = ST_LINE;
            end
        endcase
        n_in_ready  = (n_state != ST_LOAD) && (n_state != ST_SHOW);
        n_out_valid = (n_state == ST_SHOW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LINE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/symbol_list_address_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_list_address_lookup
// Finds the symbol of a text symbol list that holds a lookup address.
// ----------------------------------------------------------------------------
// i_cfg carries the lookup address; write it while no scan report is pending.
// i_item takes one list byte per word; scan_start restarts parsing at a line
// start before that byte. Lines are "<hex address> <name>\n".
// While parsing, one byte is taken every cycle and no result is produced.
// When the scan settles (address above lookup, end of list, bad name or
// format error) i_item.ready drops and the report goes out on o_result as
// one word per name character (a single word for an empty or bad name),
// with last on the final one.
// Each report word comes from a read of the name store register, then the
// word is held until the receiver takes it. A stalled receiver holds
// the word and the input stays closed. After the report, bytes are taken and
// dropped until the next scan_start.
// Reset clears the parser, the accumulators and the lookup address; the
// name store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module symbol_list_address_lookup import slal_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int NAME_LEN  = NAME_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slal_chan_if.sink   i_cfg,
    slal_chan_if.sink   i_item,
    slal_chan_if.source o_result
);

    t_dp_cmd    cmd;
    t_dp_status dp_status;
    t_item      item;
    t_result    result;
    logic       in_ready;
    logic       out_valid;

    assign item        = i_item.payload;
    assign i_item.ready = in_ready;
    assign i_cfg.ready  = 1'b1;
    assign o_result.valid   = out_valid;
    assign o_result.payload = result;

    slal_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_item.valid),
        .i_scan_start (item.scan_start),
        .i_out_ready  (o_result.ready),
        .i_status     (dp_status),
        .o_in_ready   (in_ready),
        .o_out_valid  (out_valid),
        .o_cmd        (cmd)
    );

    slal_datapath #(
        .ADDR_BITS (ADDR_BITS),
        .NAME_LEN  (NAME_LEN)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.payload),
        .i_byte     (item.list_byte),
        .i_cmd      (cmd),
        .o_status   (dp_status),
        .o_result   (result)
    );

endmodule
